// ===== hdl/hdep_pkg.sv =====
// ----------------------------------------------------------------------------
// hdep_pkg: shared types and constants of the HTTP date parser
// Parsed date record, queue sizing and calendar constants for the epoch math.
// ----------------------------------------------------------------------------
package hdep_pkg;

  // parsed fields of one date string; ok is low when the string failed
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        ok;
  } date_rec_t;

  // record queue between parser and converter; depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // calendar constants (days-from-civil, March-based years)
  localparam int ERA_DAYS    = 146097;
  localparam int CIVIL_SHIFT = 719468;
  localparam int YEAR_BASE   = 2000;
  localparam int DAY_SECS    = 86400;
  // days from the epoch to March 1st of YEAR_BASE
  localparam int DAYS_OFFSET = (YEAR_BASE / 400) * ERA_DAYS - CIVIL_SHIFT;

endpackage

// ===== hdl/hdep_front.sv =====
// ----------------------------------------------------------------------------
// hdep_front: byte-level date string parser
// Takes one character per transfer, tracks the scan state and pushes one
// date record into the queue on the byte marked last.
// ----------------------------------------------------------------------------
module hdep_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_byte,
  input  logic                in_is_last,
  input  logic                q_full,
  output logic                q_push,
  output hdep_pkg::date_rec_t q_rec
);
  import hdep_pkg::*;

  typedef enum logic [7:0] {
    PH_DAY   = 8'b0000_0001,
    PH_MON   = 8'b0000_0010,
    PH_YEAR  = 8'b0000_0100,
    PH_HOUR  = 8'b0000_1000,
    PH_MIN   = 8'b0001_0000,
    PH_SEC   = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_ENDED = 8'b1000_0000
  } phase_t;

  // position inside a number field
  localparam logic [1:0] CNT_NONE   = 2'd0;
  localparam logic [1:0] CNT_SIGN   = 2'd1;
  localparam logic [1:0] CNT_DIGITS = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [13:0] ACCUM_MAX = 14'd16383;

  typedef struct packed {
    phase_t      phase;
    logic        comma;
    logic [13:0] accum;
    logic        neg;
    logic [23:0] mchars;
    logic [1:0]  mcnt;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        err;
  } pstate_t;

  typedef struct packed {
    pstate_t s;
    logic    refeed;
  } feed_res_t;

  function automatic logic [3:0] month_lookup(input logic [23:0] code);
    case (code)
      "Jan":   month_lookup = 4'd1;
      "Feb":   month_lookup = 4'd2;
      "Mar":   month_lookup = 4'd3;
      "Apr":   month_lookup = 4'd4;
      "May":   month_lookup = 4'd5;
      "Jun":   month_lookup = 4'd6;
      "Jul":   month_lookup = 4'd7;
      "Aug":   month_lookup = 4'd8;
      "Sep":   month_lookup = 4'd9;
      "Oct":   month_lookup = 4'd10;
      "Nov":   month_lookup = 4'd11;
      "Dec":   month_lookup = 4'd12;
      default: month_lookup = 4'd0;
    endcase
  endfunction

  function automatic pstate_t clear_parse(input logic comma);
    pstate_t r;
    r       = '0;
    r.phase = PH_DAY;
    r.comma = comma;
    return r;
  endfunction

  function automatic pstate_t finish_month(input pstate_t s);
    pstate_t r;
    r       = s;
    r.month = (s.mcnt == 2'd3) ? month_lookup(s.mchars) : 4'd0;
    if (r.month == 4'd0) begin
      r.err = 1'b1;
    end
    r.mchars = '0;
    r.mcnt   = CNT_NONE;
    r.phase  = PH_YEAR;
    return r;
  endfunction

  function automatic pstate_t finish_number(input pstate_t s);
    pstate_t     r;
    logic [13:0] v;
    logic        neg;
    logic        bad;
    r   = s;
    v   = s.accum;
    neg = s.neg && (v != 14'd0);
    bad = 1'b0;
    case (s.phase)
      PH_DAY: begin
        bad = neg || (v < 14'd1) || (v > 14'd31);
        if (!bad) r.day = v[4:0];
        r.phase = PH_MON;
      end
      PH_YEAR: begin
        bad = neg || (v < 14'd2020) || (v > 14'd2099);
        if (!bad) r.year = v[11:0];
        r.phase = PH_HOUR;
      end
      PH_HOUR: begin
        bad = neg || (v > 14'd23);
        if (!bad) r.hour = v[4:0];
        r.phase = PH_MIN;
      end
      PH_MIN: begin
        bad = neg || (v > 14'd59);
        if (!bad) r.minute = v[5:0];
        r.phase = PH_SEC;
      end
      PH_SEC: begin
        bad = neg || (v > 14'd60);
        if (!bad) r.second = v[5:0];
        r.phase = PH_DONE;
      end
      default: bad = 1'b1;
    endcase
    if (bad) r.err = 1'b1;
    r.accum = '0;
    r.neg   = 1'b0;
    r.mcnt  = CNT_NONE;
    return r;
  endfunction

  // one scan step; refeed asks for the same byte again after a day or year
  function automatic feed_res_t feed_core(input pstate_t s, input logic [7:0] c);
    feed_res_t   f;
    logic        digit;
    logic        ws;
    logic [13:0] dval;
    logic [17:0] t;
    f.s      = s;
    f.refeed = 1'b0;
    digit    = (c >= 8'h30) && (c <= 8'h39);
    ws       = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    dval     = {10'd0, c[3:0]};
    t        = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1) + {14'd0, c[3:0]};
    if (s.err || s.phase == PH_DONE || s.phase == PH_ENDED) begin
      f.s = s;
    end else if (s.phase == PH_MON) begin
      if (ws) begin
        if (s.mcnt != CNT_NONE) f.s = finish_month(s);
      end else begin
        f.s.mchars = {s.mchars[15:0], c};
        f.s.mcnt   = s.mcnt + 2'd1;
        if (s.mcnt == 2'd2) f.s = finish_month(f.s);
      end
    end else begin
      case (s.mcnt)
        CNT_NONE: begin
          if (ws) begin
            f.s = s;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            f.s.neg  = (c == CH_MINUS);
            f.s.mcnt = CNT_SIGN;
          end else if (digit) begin
            f.s.accum = dval;
            f.s.mcnt  = CNT_DIGITS;
          end else begin
            f.s.err = 1'b1;
          end
        end
        CNT_SIGN: begin
          if (digit) begin
            f.s.accum = dval;
            f.s.mcnt  = CNT_DIGITS;
          end else begin
            f.s.err = 1'b1;
          end
        end
        CNT_DIGITS: begin
          if (digit) begin
            f.s.accum = (t > 18'(ACCUM_MAX)) ? ACCUM_MAX : t[13:0];
          end else begin
            f.s = finish_number(s);
            if (!f.s.err) begin
              if (s.phase == PH_DAY || s.phase == PH_YEAR) begin
                f.refeed = 1'b1;
              end else if ((s.phase == PH_HOUR || s.phase == PH_MIN) && c != CH_COLON) begin
                f.s.err = 1'b1;
              end
            end
          end
        end
        default: f.s.err = 1'b1;
      endcase
    end
    return f;
  endfunction

  function automatic pstate_t terminate(input pstate_t s);
    pstate_t r;
    r = s;
    if (!s.err && s.phase == PH_SEC && s.mcnt == CNT_DIGITS) begin
      r = finish_number(s);
    end
    if (r.phase != PH_DONE) r.err = 1'b1;
    r.phase = PH_ENDED;
    return r;
  endfunction

  pstate_t   st_r;
  pstate_t   st_nxt;
  pstate_t   step_s;
  pstate_t   end_s;
  feed_res_t f1;
  feed_res_t f2;
  logic      accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && in_is_last;

  always_comb begin
    f1     = feed_core(st_r, in_char_byte);
    f2     = feed_core(f1.s, in_char_byte);
    step_s = st_r;
    if (st_r.phase != PH_ENDED) begin
      if (in_char_byte == CH_NUL) begin
        step_s = terminate(st_r);
      end else if (in_char_byte == CH_COMMA && !st_r.comma) begin
        // restart the parse right after the first comma
        step_s = clear_parse(1'b1);
      end else begin
        step_s = f1.refeed ? f2.s : f1.s;
      end
    end
    end_s = (step_s.phase != PH_ENDED) ? terminate(step_s) : step_s;

    q_rec.day    = end_s.day;
    q_rec.month  = end_s.month;
    q_rec.year   = end_s.year;
    q_rec.hour   = end_s.hour;
    q_rec.minute = end_s.minute;
    q_rec.second = end_s.second;
    q_rec.ok     = !end_s.err && (end_s.month >= 4'd1) && (end_s.month <= 4'd12);

    st_nxt = st_r;
    if (accept) begin
      st_nxt = in_is_last ? clear_parse(1'b0) : step_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= clear_parse(1'b0);
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== hdl/hdep_queue.sv =====
// ----------------------------------------------------------------------------
// hdep_queue: short record queue between parser and converter
// Register-based FIFO of QDEPTH date records; lets either side stall alone.
// ----------------------------------------------------------------------------
module hdep_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hdep_pkg::date_rec_t wr_rec,
  output logic                full,
  input  logic                pop,
  output logic                rd_valid,
  output hdep_pkg::date_rec_t rd_rec
);
  import hdep_pkg::*;

  date_rec_t      slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;

  assign full     = (count_r == (QAW+1)'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_rec   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + (QAW+1)'(1);
    if (pop && !push) count_nxt = count_r - (QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("record pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid) else $error("record popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH)) else $error("queue count beyond depth");

endmodule

// ===== hdl/hdep_back.sv =====
// ----------------------------------------------------------------------------
// hdep_back: date record to epoch seconds converter
// Four-step sequencer: take record, day count and time of day, scale days
// to seconds, add and load the output register.
// ----------------------------------------------------------------------------
module hdep_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hdep_pkg::date_rec_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_epoch_seconds,
  output logic                out_parse_error
);
  import hdep_pkg::*;

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_DAYS = 4'b0010,
    BK_MUL  = 4'b0100,
    BK_SUM  = 4'b1000
  } bk_state_t;

  // days before the first of each month, counted from March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    case (mp)
      4'd0:    month_start = 9'd0;
      4'd1:    month_start = 9'd31;
      4'd2:    month_start = 9'd61;
      4'd3:    month_start = 9'd92;
      4'd4:    month_start = 9'd122;
      4'd5:    month_start = 9'd153;
      4'd6:    month_start = 9'd184;
      4'd7:    month_start = 9'd214;
      4'd8:    month_start = 9'd245;
      4'd9:    month_start = 9'd275;
      4'd10:   month_start = 9'd306;
      4'd11:   month_start = 9'd337;
      default: month_start = 9'd0;
    endcase
  endfunction

  bk_state_t   state_r;
  bk_state_t   state_nxt;
  date_rec_t   rec_r;
  logic [15:0] days_r;
  logic [16:0] tod_r;
  logic [31:0] prod_r;
  logic        out_valid_r;
  logic [31:0] out_epoch_r;
  logic        out_err_r;

  logic        early;
  logic [11:0] yfull;
  logic [6:0]  yoe;
  logic [3:0]  mp;
  logic [15:0] days_calc;
  logic [16:0] tod_calc;
  logic        load_out;

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = out_epoch_r;
  assign out_parse_error   = out_err_r;

  assign q_pop    = (state_r == BK_IDLE) && q_valid;
  assign load_out = (state_r == BK_SUM) && (!out_valid_r || out_ready);

  always_comb begin
    // January and February count with the previous year
    early = (rec_r.month <= 4'd2);
    yfull = rec_r.year - 12'(YEAR_BASE) - {11'd0, early};
    yoe   = yfull[6:0];
    mp    = early ? rec_r.month + 4'd9 : rec_r.month - 4'd3;
    days_calc = 16'(DAYS_OFFSET) + ({9'd0, yoe} * 16'd365) + {11'd0, yoe[6:2]}
              + {7'd0, month_start(mp)} + {11'd0, rec_r.day} - 16'd1;
    tod_calc  = ({12'd0, rec_r.hour} * 17'd3600) + ({11'd0, rec_r.minute} * 17'd60)
              + {11'd0, rec_r.second};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_DAYS;
      BK_DAYS: state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_SUM;
      BK_SUM:  if (load_out) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) rec_r <= q_rec;
    if (state_r == BK_DAYS) begin
      days_r <= days_calc;
      tod_r  <= tod_calc;
    end
    if (state_r == BK_MUL) prod_r <= {16'd0, days_r} * 32'(DAY_SECS);
    if (load_out) begin
      out_epoch_r <= rec_r.ok ? prod_r + {15'd0, tod_r} : 32'd0;
      out_err_r   <= !rec_r.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_epoch_r == 32'd0))
    else $error("failed parse with nonzero epoch");

endmodule

// ===== hdl/http_date_to_epoch_parser_core.sv =====
// ----------------------------------------------------------------------------
// http_date_to_epoch_parser_core: HTTP Date string to epoch seconds
// Path: record goes through the queue, then DAYS, MUL, SUM, then out_valid.
// Throughput: one byte per cycle while the record queue has room; the
//   converter takes one string at a time and pops the next record from idle.
// Reset: synchronous, active low; clears parser state, queue and converter.
// ----------------------------------------------------------------------------
module http_date_to_epoch_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_epoch_seconds,
  output logic        out_parse_error
);
  import hdep_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  date_rec_t q_wr_rec;
  date_rec_t q_rd_rec;

  hdep_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (q_wr_rec)
  );

  hdep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_rec   (q_wr_rec),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_rec   (q_rd_rec)
  );

  hdep_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rec             (q_rd_rec),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds),
    .out_parse_error   (out_parse_error)
  );

endmodule
